FILE: rtl/core/sre_pkg.sv
// Shared types, constants and small arithmetic helpers for the Sobel/Roberts
// edge magnitude unit. No dependencies; every other file in rtl/core uses it.
package sre_pkg;

  localparam int PIX_W      = 8;
  localparam int MAG_W      = 8;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int WSUM_W     = 10;   // a + 2b + c of three pixels
  localparam int SQ_W       = 2 * WSUM_W;
  localparam int SUM_W      = SQ_W + 2;  // even width for the root unit
  localparam int OUT_DATA_W = 40;   // 2*8 + 2*12 = 40, already whole bytes

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int MIN_SIZE       = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
  localparam logic [MAG_W-1:0]  MAG_MAX      = MAG_W'(255);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_GRAD,
    ST_SQUARE,
    ST_LAUNCH,
    ST_ROOT,
    ST_EMIT
  } state_t;

  // a + 2b + c, max 1020
  function automatic logic [WSUM_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
    logic [WSUM_W-1:0] s;
    s = WSUM_W'(a) + WSUM_W'({b, 1'b0}) + WSUM_W'(c);
    return s;
  endfunction

  function automatic logic [WSUM_W-1:0] absdiff(input logic [WSUM_W-1:0] p,
                                                input logic [WSUM_W-1:0] n);
    logic [WSUM_W-1:0] d;
    d = (p >= n) ? (p - n) : (n - p);
    return d;
  endfunction

endpackage

FILE: rtl/core/sre_line_mem.sv
// Line store memory: upper and middle row pixels packed in one word per column.
// Synchronous read: the read data is registered. Depends on sre_pkg.
module sre_line_mem #(
  parameter int DEPTH = sre_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [2*sre_pkg::PIX_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [2*sre_pkg::PIX_W-1:0] wr_data
);

  logic [2*sre_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/sre_isqrt.sv
// Iterative floor square root, one result bit per cycle (digit recurrence).
// Depends on sre_pkg for the default input width.
module sre_isqrt #(
  parameter int IN_W = sre_pkg::SUM_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                done,
  input  logic [IN_W-1:0]     radicand,
  output logic [IN_W/2-1:0]   root
);

  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [IN_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem_sh = {rem[REM_W-3:0], rad[IN_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[IN_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/sobel_roberts_edge_magnitude_unit.sv
// Top level of the Sobel/Roberts edge magnitude unit: counters, 3x3 window,
// gradient datapath and sequencer. Depends on sre_pkg, sre_line_mem, sre_isqrt.
//
// Grayscale pixels enter one item at a time on the s_ stream in raster order.
// The two rows above the current one live in a single line memory (one word
// per column, upper and middle pixel side by side) read at the moment the
// pixel is taken; the read data, the new pixel and the previous two columns
// form the 3x3 window. For every pixel whose window center is interior, the
// unit emits one item on the m_ stream holding the Sobel magnitude
// floor(sqrt(Gx^2+Gy^2)), the Roberts cross magnitude of the lower-right 2x2
// of the window, both saturated at 255, and the row and column of the center
// pixel; m_tlast marks the last interior result of the frame. Border pixels
// produce no output. An interior pixel's time is dominated by the square-root
// unit, which settles one root bit per cycle. The next pixel is taken as soon
// as the previous one is handed to the output register, even if that result
// is still waiting for m_tready. image_width (index 0) and image_height
// (index 1) are written through the cfg_ port while the unit is idle; this is
// the user's rule, which the unit does not enforce. Sizes are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT, and any write restarts the frame at row 0,
// column 0. No line memory clearing after reset is needed: each frame writes
// its first two rows before any result reads them.
module sobel_roberts_edge_magnitude_unit #(
  parameter int MAX_WIDTH  = sre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sre_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Pixel input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sre_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel
  // Result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] sobel_mag, [15:8] roberts_mag, [27:16] out_row, [39:28] out_col
  output logic [sre_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,   // frame_last
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sre_pkg::SIZE_W-1:0]        cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CLW   = $clog2(MAX_WIDTH + 1);
  localparam int CLH   = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W = sre_pkg::SIZE_W + 1;
  localparam int PW    = sre_pkg::PIX_W;
  localparam int GW    = sre_pkg::WSUM_W;
  localparam int ROOT_W = sre_pkg::SUM_W / 2;

  // Configuration registers
  logic [sre_pkg::SIZE_W-1:0] image_width;
  logic [sre_pkg::SIZE_W-1:0] image_height;
  logic [CLW-1:0]             width_eff;
  logic [CLH-1:0]             height_eff;
  logic                       cfg_write;

  // Position counters and the captured position of the item in flight
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] item_col;
  logic [RW-1:0] item_row;
  logic          item_interior;
  logic          item_last;
  logic [PW-1:0] item_pixel;
  logic          last_col;
  logic          last_row;

  // Window, gradients and squares
  logic [PW-1:0] win [9];
  logic [GW-1:0] abs_gx, abs_gy, abs_d1, abs_d2;
  logic [sre_pkg::SQ_W-1:0] sq_gx, sq_gy, sq_d1, sq_d2;

  // Line memory
  logic [2*PW-1:0] rd_data;
  logic            rd_en;
  logic            wr_en;

  // Root units
  logic               sobel_done;
  logic               roberts_done;
  logic [ROOT_W-1:0]  sobel_root;
  logic [ROOT_W-1:0]  roberts_root;
  logic               root_start;

  // Sequencer
  sre_pkg::state_t state;
  sre_pkg::state_t state_next;
  logic            accept;
  logic            out_load;

  // Output register fields
  logic [sre_pkg::MAG_W-1:0] sobel_mag;
  logic [sre_pkg::MAG_W-1:0] roberts_mag;
  logic [sre_pkg::POS_W-1:0] out_row;
  logic [sre_pkg::POS_W-1:0] out_col;
  logic [RW-1:0]             row_less;
  logic [CW-1:0]             col_less;

  // ---------------------------------------------------------------------
  // Configuration: always ready; any write restarts the frame.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sre_pkg::WIDTH_RESET;
      image_height <= sre_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sre_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        sre_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to the supported range
  always_comb begin
    if (image_width < sre_pkg::SIZE_W'(sre_pkg::MIN_SIZE)) begin
      width_eff = CLW'(sre_pkg::MIN_SIZE);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      width_eff = CLW'(MAX_WIDTH);
    end else begin
      width_eff = CLW'(image_width);
    end
    if (image_height < sre_pkg::SIZE_W'(sre_pkg::MIN_SIZE)) begin
      height_eff = CLH'(sre_pkg::MIN_SIZE);
    end else if (CMP_W'(image_height) > CMP_W'(MAX_HEIGHT)) begin
      height_eff = CLH'(MAX_HEIGHT);
    end else begin
      height_eff = CLH'(image_height);
    end
  end

  assign last_col = CLW'(col_count) == (width_eff - CLW'(1));
  assign last_row = CLH'(row_count) == (height_eff - CLH'(1));
  assign accept   = s_tvalid && s_tready;

  // Advance the raster position on every accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_write) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // Capture the item and its position; the line memory read goes out now
  always_ff @(posedge clk) begin
    if (accept) begin
      item_pixel    <= s_tdata;
      item_col      <= col_count;
      item_row      <= row_count;
      item_interior <= (col_count >= CW'(2)) && (row_count >= RW'(2));
      item_last     <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------
  // Line memory: read at accept, write back in the following cycle at the same
  // column. Successive items hit different columns, and the write lands
  // before the next read, so no forwarding is needed.
  // ---------------------------------------------------------------------
  sre_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (col_count),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (item_col),
    .wr_data ({rd_data[PW-1:0], item_pixel})   // upper <= middle, middle <= pixel
  );

  // Window: shift left, new column on the right (upper, middle, current)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (state == sre_pkg::ST_WINDOW) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= rd_data[2*PW-1:PW];
      win[5] <= rd_data[PW-1:0];
      win[8] <= item_pixel;
    end
  end

  // Gradient magnitudes as absolute differences of weighted sums
  always_ff @(posedge clk) begin
    if (state == sre_pkg::ST_GRAD) begin
      abs_gx <= sre_pkg::absdiff(sre_pkg::wsum(win[2], win[5], win[8]),
                                 sre_pkg::wsum(win[0], win[3], win[6]));
      abs_gy <= sre_pkg::absdiff(sre_pkg::wsum(win[6], win[7], win[8]),
                                 sre_pkg::wsum(win[0], win[1], win[2]));
      abs_d1 <= sre_pkg::absdiff(GW'(win[4]), GW'(win[8]));
      abs_d2 <= sre_pkg::absdiff(GW'(win[5]), GW'(win[7]));
    end
  end

  always_ff @(posedge clk) begin
    if (state == sre_pkg::ST_SQUARE) begin
      sq_gx <= abs_gx * abs_gx;
      sq_gy <= abs_gy * abs_gy;
      sq_d1 <= abs_d1 * abs_d1;
      sq_d2 <= abs_d2 * abs_d2;
    end
  end

  // ---------------------------------------------------------------------
  // Square roots: two units run side by side with equal latency
  // ---------------------------------------------------------------------
  sre_isqrt #(.IN_W(sre_pkg::SUM_W)) u_sobel_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .done     (sobel_done),
    .radicand (sre_pkg::SUM_W'(sq_gx) + sre_pkg::SUM_W'(sq_gy)),
    .root     (sobel_root)
  );

  sre_isqrt #(.IN_W(sre_pkg::SUM_W)) u_roberts_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .done     (roberts_done),
    .radicand (sre_pkg::SUM_W'(sq_d1) + sre_pkg::SUM_W'(sq_d2)),
    .root     (roberts_root)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sre_pkg::ST_IDLE:   if (accept) state_next = sre_pkg::ST_WINDOW;
      sre_pkg::ST_WINDOW: state_next = item_interior ? sre_pkg::ST_GRAD : sre_pkg::ST_IDLE;
      sre_pkg::ST_GRAD:   state_next = sre_pkg::ST_SQUARE;
      sre_pkg::ST_SQUARE: state_next = sre_pkg::ST_LAUNCH;
      sre_pkg::ST_LAUNCH: state_next = sre_pkg::ST_ROOT;
      sre_pkg::ST_ROOT:   if (sobel_done && roberts_done) state_next = sre_pkg::ST_EMIT;
      sre_pkg::ST_EMIT:   if (!m_tvalid || m_tready) state_next = sre_pkg::ST_IDLE;
      default:            state_next = sre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = state == sre_pkg::ST_IDLE;
    rd_en      = s_tvalid && (state == sre_pkg::ST_IDLE);
    wr_en      = state == sre_pkg::ST_WINDOW;
    root_start = state == sre_pkg::ST_LAUNCH;
    out_load   = (state == sre_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  end

  // ---------------------------------------------------------------------
  // Output register: hold the result until taken
  // ---------------------------------------------------------------------
  assign row_less = item_row - RW'(1);
  assign col_less = item_col - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sobel_mag   <= (sobel_root > ROOT_W'(sre_pkg::MAG_MAX)) ?
                     sre_pkg::MAG_MAX : sobel_root[sre_pkg::MAG_W-1:0];
      roberts_mag <= (roberts_root > ROOT_W'(sre_pkg::MAG_MAX)) ?
                     sre_pkg::MAG_MAX : roberts_root[sre_pkg::MAG_W-1:0];
      out_row     <= sre_pkg::POS_W'(row_less);
      out_col     <= sre_pkg::POS_W'(col_less);
      m_tlast     <= item_last;
    end
  end

  assign m_tdata = {out_col, out_row, roberts_mag, sobel_mag};

endmodule
